[rtl/core/lmbp_pkg.sv]
// ----------------------------------------------------------------------------
// lmbp_pkg
// shared types, constants and helpers of the led matrix bit-plane row scanner
// ----------------------------------------------------------------------------
package lmbp_pkg;

  // default geometry
  localparam int unsigned ColumnWordsDefault = 6;
  localparam int unsigned PlanesDefault      = 8;

  // fixed matrix constants
  localparam logic [3:0] RowLast = 4'd15;

  // queue depths
  localparam int unsigned CmdQDepth = 2;
  localparam int unsigned OutQDepth = 4;

  // item codes on the func field
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncTick  = 1'b1;

  // classified command handed from front to back
  typedef struct packed {
    logic        is_tick;
    logic [3:0]  col;      // write column
    logic [3:0]  row;      // write row, or new scan row of a tick
    logic [2:0]  plane;    // write plane, or scheduled plane of a tick
    logic [15:0] word;     // write data
    logic        blank;    // tick plane out of range, words read as zero
    logic [3:0]  row_off;  // old scan row of a tick
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [3:0]  col;
    logic [15:0] word;
    logic [3:0]  row_off;
    logic [3:0]  row_on;
    logic        last;
  } res_t;

  function automatic logic [15:0] byte_swap(input logic [15:0] w);
    byte_swap = {w[7:0], w[15:8]};
  endfunction

endpackage

[rtl/core/lmbp_fifo.sv]
// ----------------------------------------------------------------------------
// lmbp_fifo
// small register queue, used between front and back and for results
// ----------------------------------------------------------------------------
module lmbp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             wdata_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             rdata_o,
  output logic                         empty_o,
  output logic                         full_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(DEPTH));
  assign count_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/core/lmbp_front.sv]
// ----------------------------------------------------------------------------
// lmbp_front
// accepts items, keeps scan row, slot counter and schedule, classifies items
// ----------------------------------------------------------------------------
module lmbp_front #(
  parameter int unsigned COLUMN_WORDS = lmbp_pkg::ColumnWordsDefault,
  parameter int unsigned PLANES       = lmbp_pkg::PlanesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic                func_i,
  input  logic [3:0]          column_slot_i,
  input  logic [3:0]          row_index_i,
  input  logic [2:0]          plane_index_i,
  input  logic [15:0]         pixel_word_i,
  input  logic                plane_schedule_we_i,
  input  logic [23:0]         plane_schedule_i,
  input  logic                clearing_i,
  input  logic                cmd_full_i,
  output logic                cmd_push_o,
  output lmbp_pkg::cmd_t      cmd_o
);
  import lmbp_pkg::*;

  localparam logic [4:0] ColCount   = 5'(COLUMN_WORDS);
  localparam logic [3:0] PlaneCount = 4'(PLANES);

  logic [23:0] sched_q;
  logic [3:0]  row_q, row_d;
  logic [2:0]  slot_q, slot_d;
  logic [4:0]  slot_lsb;
  logic [2:0]  tick_plane;
  logic        accept, write_ok;

  assign full_o   = cmd_full_i || clearing_i;
  assign accept   = push_i && !full_o;
  assign slot_lsb = {2'b00, slot_q} * 5'd3;
  assign tick_plane = sched_q[slot_lsb +: 3];
  assign write_ok = ({1'b0, column_slot_i} < ColCount) && ({1'b0, plane_index_i} < PlaneCount);

  always_comb begin
    row_d  = row_q;
    slot_d = slot_q;
    cmd_o  = '0;
    cmd_push_o = 1'b0;
    if (func_i == FuncTick) begin
      cmd_o.is_tick = 1'b1;
      cmd_o.row     = row_q + 1'b1;
      cmd_o.row_off = row_q;
      cmd_o.plane   = tick_plane;
      cmd_o.blank   = !({1'b0, tick_plane} < PlaneCount);
      cmd_push_o    = accept;
      if (accept) begin
        row_d = row_q + 1'b1;
        // each row wrap moves on to the next schedule slot
        if (row_q == RowLast) begin
          slot_d = slot_q + 1'b1;
        end
      end
    end else begin
      cmd_o.is_tick = 1'b0;
      cmd_o.col     = column_slot_i;
      cmd_o.row     = row_index_i;
      cmd_o.plane   = plane_index_i;
      cmd_o.word    = pixel_word_i;
      cmd_push_o    = accept && write_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_q <= '0;
      row_q   <= '0;
      slot_q  <= '0;
    end else begin
      row_q  <= row_d;
      slot_q <= slot_d;
      if (plane_schedule_we_i) begin
        sched_q <= plane_schedule_i;
      end
    end
  end

endmodule

[rtl/core/lmbp_back.sv]
// ----------------------------------------------------------------------------
// lmbp_back
// owns the frame store: clears it after reset, does writes, scans out ticks
// ----------------------------------------------------------------------------
module lmbp_back #(
  parameter int unsigned COLUMN_WORDS = lmbp_pkg::ColumnWordsDefault,
  parameter int unsigned PLANES       = lmbp_pkg::PlanesDefault
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cmd_empty_i,
  input  lmbp_pkg::cmd_t                             cmd_i,
  output logic                                       cmd_pop_o,
  input  logic [$clog2(lmbp_pkg::OutQDepth+1)-1:0]   out_count_i,
  output logic                                       res_push_o,
  output lmbp_pkg::res_t                             res_o,
  output logic                                       clearing_o
);
  import lmbp_pkg::*;

  localparam int unsigned ColW  = (COLUMN_WORDS > 1) ? $clog2(COLUMN_WORDS) : 1;
  localparam int unsigned PlW   = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int unsigned AddrW = ColW + 4 + PlW;
  localparam int unsigned Depth = 1 << AddrW;
  localparam int unsigned CntW  = $clog2(OutQDepth + 1);
  localparam logic [3:0]  ColLast = 4'(COLUMN_WORDS - 1);

  localparam logic StClear = 1'b0;
  localparam logic StRun   = 1'b1;

  logic [15:0]      store_q [Depth];
  logic [15:0]      rdata_q;
  logic             state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;

  // scan state of the current tick
  logic             busy_q, busy_d;
  logic [3:0]       col_q, col_d;
  logic [3:0]       row_on_q, row_on_d, row_off_q, row_off_d;
  logic [2:0]       plane_q, plane_d;
  logic             blank_q, blank_d;

  // read pipeline side data
  logic             rd_valid_q;
  res_t             rd_meta_q;
  logic             rd_blank_q;

  logic             credit, issue, last_issue, take;
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [15:0]      wdata;

  function automatic logic [AddrW-1:0] addr(input logic [3:0] c, input logic [3:0] r,
                                            input logic [2:0] p);
    addr = {c[ColW-1:0], r, p[PlW-1:0]};
  endfunction

  assign clearing_o = (state_q == StClear);

  // room for every read in flight
  assign credit = (({1'b0, out_count_i} + (CntW + 1)'(rd_valid_q)) < (CntW + 1)'(OutQDepth));
  assign issue      = busy_q && credit;
  assign last_issue = issue && (col_q == ColLast);
  assign take       = !clearing_o && !cmd_empty_i && (!busy_q || last_issue);
  assign cmd_pop_o  = take;

  assign raddr = addr(col_q, row_on_q, plane_q);

  always_comb begin
    we    = 1'b0;
    waddr = addr(cmd_i.col, cmd_i.row, cmd_i.plane);
    wdata = cmd_i.word;
    if (clearing_o) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (take && !cmd_i.is_tick) begin
      we = 1'b1;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    busy_d    = busy_q;
    col_d     = col_q;
    row_on_d  = row_on_q;
    row_off_d = row_off_q;
    plane_d   = plane_q;
    blank_d   = blank_q;
    case (state_q)
      StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (issue) begin
          col_d = col_q + 1'b1;
        end
        if (last_issue) begin
          busy_d = 1'b0;
        end
        if (take && cmd_i.is_tick) begin
          busy_d    = 1'b1;
          col_d     = '0;
          row_on_d  = cmd_i.row;
          row_off_d = cmd_i.row_off;
          plane_d   = cmd_i.plane;
          blank_d   = cmd_i.blank;
        end
      end
      default: state_d = StClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_q      <= '0;
      busy_q     <= 1'b0;
      col_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      busy_q     <= busy_d;
      col_q      <= col_d;
      rd_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    row_on_q  <= row_on_d;
    row_off_q <= row_off_d;
    plane_q   <= plane_d;
    blank_q   <= blank_d;
    if (issue) begin
      rd_meta_q.col     <= col_q;
      rd_meta_q.word    <= '0;
      rd_meta_q.row_off <= row_off_q;
      rd_meta_q.row_on  <= row_on_q;
      rd_meta_q.last    <= (col_q == ColLast);
      rd_blank_q        <= blank_q;
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= wdata;
    end
    if (issue) begin
      rdata_q <= store_q[raddr];
    end
  end

  always_comb begin
    res_o      = rd_meta_q;
    res_o.word = rd_blank_q ? 16'h0000 : byte_swap(rdata_q);
  end
  assign res_push_o = rd_valid_q;

endmodule

[rtl/core/led_matrix_bit_plane_row_scanner.sv]
// ----------------------------------------------------------------------------
// led_matrix_bit_plane_row_scanner
// multiplexed led matrix scanner with a bit-plane frame store
// ----------------------------------------------------------------------------
// Items enter through a push/full queue port and results leave through an
// empty/pop queue port. A write item stores one 16-pixel column word and
// produces no result; a tick item advances the scan row (and the schedule
// slot on each row wrap) and produces COLUMN_WORDS results, one per column,
// with the last one flagged. After reset the frame store is cleared, one
// word per cycle, over all 2**(clog2(COLUMN_WORDS) + 4 + clog2(PLANES))
// words (1024 with the defaults), during which full stays high. After that
// a write goes straight into the store and a tick is scanned out with one
// frame store read per cycle while the result queue has room, so a stream of
// ticks gives one result per cycle while the result side keeps popping. A
// small command queue sits between the classifying front and the store side,
// so items are taken while a tick is still being scanned out.
module led_matrix_bit_plane_row_scanner #(
  parameter int unsigned COLUMN_WORDS = lmbp_pkg::ColumnWordsDefault,
  parameter int unsigned PLANES       = lmbp_pkg::PlanesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item side
  input  logic        push,
  output logic        full,
  input  logic        func_i,
  input  logic [3:0]  column_slot_i,
  input  logic [3:0]  row_index_i,
  input  logic [2:0]  plane_index_i,
  input  logic [15:0] pixel_word_i,
  // configuration
  input  logic        plane_schedule_we_i,
  input  logic [23:0] plane_schedule_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_column_o,
  output logic [15:0] swapped_word_o,
  output logic [3:0]  row_off_o,
  output logic [3:0]  row_on_o,
  output logic        last_o
);
  import lmbp_pkg::*;

  localparam int unsigned OutCntW = $clog2(OutQDepth + 1);

  // front to command queue
  logic   cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t   cmd_in, cmd_head;
  logic   clearing;

  // back to result queue
  logic               res_push;
  res_t               res_in, res_head;
  logic [OutCntW-1:0] out_count;

  lmbp_front #(
    .COLUMN_WORDS (COLUMN_WORDS),
    .PLANES       (PLANES)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push_i              (push),
    .full_o              (full),
    .func_i              (func_i),
    .column_slot_i       (column_slot_i),
    .row_index_i         (row_index_i),
    .plane_index_i       (plane_index_i),
    .pixel_word_i        (pixel_word_i),
    .plane_schedule_we_i (plane_schedule_we_i),
    .plane_schedule_i    (plane_schedule_i),
    .clearing_i          (clearing),
    .cmd_full_i          (cmd_full),
    .cmd_push_o          (cmd_push),
    .cmd_o               (cmd_in)
  );

  // commands between front and back
  lmbp_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CmdQDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty),
    .full_o  (cmd_full),
    .count_o ()
  );

  lmbp_back #(
    .COLUMN_WORDS (COLUMN_WORDS),
    .PLANES       (PLANES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .out_count_i (out_count),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .clearing_o  (clearing)
  );

  // result queue, the back only issues reads it has room for
  lmbp_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OutQDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .pop_i   (pop),
    .rdata_o (res_head),
    .empty_o (empty),
    .full_o  (),
    .count_o (out_count)
  );

  assign out_column_o   = res_head.col;
  assign swapped_word_o = res_head.word;
  assign row_off_o      = res_head.row_off;
  assign row_on_o       = res_head.row_on;
  assign last_o         = res_head.last;

endmodule

[rtl/core/lmbp_checker.sv]
// ----------------------------------------------------------------------------
// lmbp_checker
// port-level checks of the led matrix bit-plane row scanner
// ----------------------------------------------------------------------------
module lmbp_checker #(
  parameter int unsigned COLUMN_WORDS = lmbp_pkg::ColumnWordsDefault,
  parameter int unsigned PLANES       = lmbp_pkg::PlanesDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [3:0]  out_column_o,
  input logic [3:0]  row_off_o,
  input logic [3:0]  row_on_o,
  input logic        last_o
);
  localparam logic [3:0] ColLast = 4'(COLUMN_WORDS - 1);

  // a waiting item stays until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result item dropped before pop");

  // last flag marks exactly the final column
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_o == (out_column_o == ColLast)))
    else $error("last flag does not match column");

  // the row switched on follows the row switched off
  a_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (row_on_o == 4'(row_off_o + 4'd1)))
    else $error("row on is not the row after row off");

  // columns of one tick come out in order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) ##1 !empty |->
      (out_column_o == 4'($past(out_column_o) + 4'd1)))
    else $error("column out of order");

endmodule

bind led_matrix_bit_plane_row_scanner lmbp_checker #(
  .COLUMN_WORDS (COLUMN_WORDS),
  .PLANES       (PLANES)
) u_lmbp_checker (.*);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// led matrix bit-plane row scanner: frame store writes and scan ticks
// ----------------------------------------------------------------------------
// A scoreboard model of the frame store, scan row, slot counter and plane
// schedule runs alongside the block. Every accepted item updates the model, and
// every tick queues the column words it should produce. A receiver process
// pops results under random stalls and compares each one with the oldest
// queued column word. Phases run directed items, then random traffic under
// several schedules, a stretch with no idling, and a long result stall that
// backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lmbp_pkg::*;

  localparam int unsigned ColWords     = ColumnWordsDefault;
  localparam int unsigned Planes       = PlanesDefault;
  localparam int unsigned SettleCycles = 32;    // writes in flight behind the last tick
  localparam int unsigned StallLimit   = 4000;  // covers the store clear after reset
  localparam int unsigned LongHold     = 300;
  localparam int unsigned MaxReports   = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        func_i;
  logic [3:0]  column_slot_i;
  logic [3:0]  row_index_i;
  logic [2:0]  plane_index_i;
  logic [15:0] pixel_word_i;
  logic        plane_schedule_we_i;
  logic [23:0] plane_schedule_i;
  logic        empty;
  logic        pop;
  logic [3:0]  out_column_o;
  logic [15:0] swapped_word_o;
  logic [3:0]  row_off_o;
  logic [3:0]  row_on_o;
  logic        last_o;

  // scoreboard copy of the block state
  logic [15:0] frame_model [ColWords][16][Planes];
  logic [3:0]  scan_row_model;
  logic [2:0]  slot_model;
  logic [23:0] schedule_model;

  // column words still owed by the block, oldest first
  res_t columns_due [$];

  int unsigned fault_count  = 0;
  bit          idle_enable  = 1'b1;
  int unsigned hold_request = 0;

  always #5 clk_i = ~clk_i;

  led_matrix_bit_plane_row_scanner #(
    .COLUMN_WORDS (ColWords),
    .PLANES       (Planes)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .func_i              (func_i),
    .column_slot_i       (column_slot_i),
    .row_index_i         (row_index_i),
    .plane_index_i       (plane_index_i),
    .pixel_word_i        (pixel_word_i),
    .plane_schedule_we_i (plane_schedule_we_i),
    .plane_schedule_i    (plane_schedule_i),
    .empty               (empty),
    .pop                 (pop),
    .out_column_o        (out_column_o),
    .swapped_word_o      (swapped_word_o),
    .row_off_o           (row_off_o),
    .row_on_o            (row_on_o),
    .last_o              (last_o)
  );

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= MaxReports) begin
      $display("%t  %s", $realtime, msg);
    end
  endfunction

  // update the model with one accepted item and queue the words it yields
  function automatic void predict_scan(input logic fn, input logic [3:0] col,
                                       input logic [3:0] row, input logic [2:0] plane,
                                       input logic [15:0] word);
    logic [2:0]  shown;
    logic [3:0]  old_row;
    logic [15:0] d;
    res_t        r;
    if (fn == FuncWrite) begin
      // writes past the configured columns or planes are dropped
      if (col < ColWords && plane < Planes) begin
        frame_model[col][row][plane] = word;
      end
    end else begin
      // plane comes from the slot as it was before this tick
      shown   = schedule_model[3*slot_model +: 3];
      old_row = scan_row_model;
      if (scan_row_model == RowLast) begin
        slot_model = slot_model + 3'd1;
      end
      scan_row_model = scan_row_model + 4'd1;
      for (int c = 0; c < ColWords; c++) begin
        // a scheduled plane beyond the store reads as blank
        d         = (shown < Planes) ? frame_model[c][scan_row_model][shown] : 16'h0000;
        r.col     = 4'(c);
        r.word    = {d[7:0], d[15:8]};
        r.row_off = old_row;
        r.row_on  = scan_row_model;
        r.last    = (c == ColWords - 1);
        columns_due.push_back(r);
      end
    end
  endfunction

  // offer one item after a random gap, hold it until the block takes it
  task automatic send_item(input logic fn, input logic [3:0] col, input logic [3:0] row,
                           input logic [2:0] plane, input logic [15:0] word);
    int unsigned gap;
    gap = idle_enable ? $urandom_range(0, 10) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push          <= 1'b1;
    func_i        <= fn;
    column_slot_i <= col;
    row_index_i   <= row;
    plane_index_i <= plane;
    pixel_word_i  <= word;
    do @(posedge clk_i); while (full);
    predict_scan(fn, col, row, plane, word);
  endtask

  // tick with random junk in the fields it ignores
  task automatic scan_tick();
    send_item(FuncTick, 4'($urandom), 4'($urandom), 3'($urandom), 16'($urandom));
  endtask

  task automatic write_word(input logic [3:0] col, input logic [3:0] row,
                            input logic [2:0] plane, input logic [15:0] word);
    send_item(FuncWrite, col, row, plane, word);
  endtask

  // stop offering, wait for every owed word, then let trailing writes land
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (columns_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_schedule(input logic [23:0] value);
    settle();
    @(negedge clk_i);
    plane_schedule_we_i <= 1'b1;
    plane_schedule_i    <= value;
    @(negedge clk_i);
    plane_schedule_we_i <= 1'b0;
    schedule_model = value;
  endtask

  // mixed ticks and writes; writes lean toward rows and planes about to be shown
  task automatic run_traffic(input int unsigned count);
    logic [3:0] col;
    logic [3:0] row;
    logic [2:0] plane;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 55) begin
        scan_tick();
      end else begin
        col   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(ColWords, 15))
                                            : 4'($urandom_range(0, ColWords - 1));
        row   = $urandom_range(0, 1) ? 4'(scan_row_model + $urandom_range(1, 4))
                                     : 4'($urandom);
        plane = $urandom_range(0, 1) ? schedule_model[3*slot_model +: 3]
                                     : 3'($urandom);
        write_word(col, row, plane, 16'($urandom));
      end
    end
  endtask

  task automatic test_directed();
    // every slot shows plane 0
    set_schedule(24'h000000);
    // row 1 plane 0, extreme and lopsided words across all columns
    write_word(4'd0, 4'd1, 3'd0, 16'hFFFF);
    write_word(4'd1, 4'd1, 3'd0, 16'h00FF);
    write_word(4'd2, 4'd1, 3'd0, 16'hFF00);
    write_word(4'd3, 4'd1, 3'd0, 16'h1234);
    write_word(4'd4, 4'd1, 3'd0, 16'h8001);
    write_word(4'(ColWords - 1), 4'd1, 3'd0, 16'h7FFE);
    // columns past the configured count must not land anywhere
    write_word(4'(ColWords), 4'd1, 3'd0, 16'hDEAD);
    write_word(4'd15, 4'd2, 3'd0, 16'hBEEF);
    // other planes stay hidden while plane 0 is scheduled
    write_word(4'd0, 4'd1, 3'd7, 16'hA5A5);
    write_word(4'(ColWords - 1), 4'd15, 3'd7, 16'hFFFF);
    write_word(4'd0, 4'd0, 3'd0, 16'h0001);
    scan_tick();
    scan_tick();
    // overwrite a word, including with zero, before its row comes up
    write_word(4'd2, 4'd3, 3'd0, 16'h5AA5);
    write_word(4'd2, 4'd3, 3'd0, 16'h0000);
    write_word(4'd3, 4'd3, 3'd0, 16'hC3C3);
    scan_tick();
  endtask

  task automatic test_schedule_sweep();
    // slot k shows plane k
    set_schedule(24'o76543210);
    run_traffic(55);
    // all slots on the top plane
    set_schedule(24'hFFFFFF);
    run_traffic(55);
    set_schedule(24'($urandom));
    run_traffic(55);
  endtask

  task automatic test_back_to_back();
    set_schedule(24'($urandom));
    idle_enable = 1'b0;
    run_traffic(45);
    idle_enable = 1'b1;
  endtask

  task automatic test_full_stall();
    set_schedule(24'o01234567);
    // receiver sits out a long stretch while ticks keep coming
    hold_request = LongHold;
    repeat (24) scan_tick();
  endtask

  // result side: random stalls, one long hold on request
  initial begin : result_side
    int unsigned gap;
    res_t        got;
    res_t        want;
    pop = 1'b0;
    forever begin
      if (hold_request != 0) begin
        gap          = hold_request;
        hold_request = 0;
      end else begin
        gap = idle_enable ? $urandom_range(0, 10) : 0;
      end
      @(negedge clk_i);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got = '{col: out_column_o, word: swapped_word_o, row_off: row_off_o,
              row_on: row_on_o, last: last_o};
      if (columns_due.size() == 0) begin
        note_fault($sformatf("column word with nothing owed: col %0d word %04h",
                             got.col, got.word));
      end else begin
        want = columns_due.pop_front();
        if (got.col !== want.col || got.word !== want.word ||
            got.row_off !== want.row_off || got.row_on !== want.row_on ||
            got.last !== want.last) begin
          note_fault($sformatf(
            "mismatch: want col %0d word %04h off %0d on %0d last %0b, got %0d %04h %0d %0d %0b",
            want.col, want.word, want.row_off, want.row_on, want.last,
            got.col, got.word, got.row_off, got.row_on, got.last));
        end
      end
    end
  end

  // ends the run once nothing has moved on either side for too long
  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    rst_ni              = 1'b0;
    push                = 1'b0;
    func_i              = FuncWrite;
    column_slot_i       = '0;
    row_index_i         = '0;
    plane_index_i       = '0;
    pixel_word_i        = '0;
    plane_schedule_we_i = 1'b0;
    plane_schedule_i    = '0;
    foreach (frame_model[c, r, p]) frame_model[c][r][p] = 16'h0000;
    scan_row_model = '0;
    slot_model     = '0;
    schedule_model = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_schedule_sweep();
    test_back_to_back();
    test_full_stall();
    settle();

    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
